### hdl/arplt_pkg.sv
// ----------------------------------------------------------------------------
// arplt_pkg
// Shared types and constants for the ARP learning table.
// ----------------------------------------------------------------------------
package arplt_pkg;

    localparam int MAC_W    = 48;
    localparam int IP_W     = 32;
    localparam int OP_W     = 16;
    localparam int IFACE_W  = 4;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int TOTAL_W  = 6;

    localparam logic [MAC_W-1:0] MAC_BCAST = '1;

    localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;
    localparam logic [OP_W-1:0] OP_REPLY   = 16'd2;

    localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_KNOWN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BCAST = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [MAC_W-1:0]   frame_src_mac;
        logic [MAC_W-1:0]   arp_sender_hw;
        logic [OP_W-1:0]    arp_opcode;
        logic [IP_W-1:0]    sender_proto_ip;
        logic [IFACE_W-1:0] iface_index;
    } arp_frame_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [TOTAL_W-1:0]  entry_total;
    } arp_result_t;

    // One stored table entry
    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [IP_W-1:0]    ip;
        logic [IFACE_W-1:0] iface;
    } table_entry_t;

endpackage

### hdl/arplt_table_mem.sv
// ----------------------------------------------------------------------------
// arplt_table_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arplt_table_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  arplt_pkg::table_entry_t wr_data,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output arplt_pkg::table_entry_t rd_data
);

    arplt_pkg::table_entry_t mem [DEPTH];
    arplt_pkg::table_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/arplt_scan_ctrl.sv
// ----------------------------------------------------------------------------
// arplt_scan_ctrl
// Key capture, linear scan of the entry store, append and result register.
// ----------------------------------------------------------------------------
module arplt_scan_ctrl #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int CNT_W  = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  arplt_pkg::arp_frame_t   frame,
    output logic                    busy,
    output logic                    result_valid,
    output arplt_pkg::arp_result_t  result,
    output logic                    wr_en,
    output logic [ADDR_W-1:0]       wr_addr,
    output arplt_pkg::table_entry_t wr_data,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr,
    input  arplt_pkg::table_entry_t rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        rd_addr_reg, rd_addr_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic                    result_valid_reg, result_valid_next;
    logic [ADDR_W-1:0]       cmp_idx_reg, cmp_idx_next;
    arplt_pkg::table_entry_t key_reg, key_next;
    arplt_pkg::arp_result_t  result_reg, result_next;

    logic accept;
    logic is_bcast;
    logic ip_used;
    logic hit;
    logic is_full;

    assign accept   = start && (state_reg == ST_IDLE);
    assign is_bcast = (frame.frame_src_mac == arplt_pkg::MAC_BCAST) ||
                      (frame.arp_sender_hw == arplt_pkg::MAC_BCAST);
    assign ip_used  = (frame.arp_opcode == arplt_pkg::OP_REQUEST) ||
                      (frame.arp_opcode == arplt_pkg::OP_REPLY);
    assign hit      = cmp_vld_reg && (rd_data.mac == key_reg.mac) &&
                      (rd_data.ip == key_reg.ip);
    assign is_full  = (fill_reg == CNT_W'(DEPTH));

    // reads go out one per cycle; each compare happens in the cycle after its read
    assign rd_en   = (state_reg == ST_SCAN) && (rd_addr_reg < fill_reg) && !hit;
    assign rd_addr = rd_addr_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        rd_addr_next      = rd_addr_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = rd_addr_reg[ADDR_W-1:0];
        result_valid_next = 1'b0;
        key_next          = key_reg;
        result_next       = result_reg;
        wr_en             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next.mac   = frame.frame_src_mac;
                    key_next.ip    = ip_used ? frame.sender_proto_ip : '0;
                    key_next.iface = frame.iface_index;
                    if (is_bcast)
                    begin
                        result_valid_next       = 1'b1;
                        result_next.status      = arplt_pkg::STATUS_BCAST;
                        result_next.slot_index  = '0;
                        result_next.entry_total = arplt_pkg::TOTAL_W'(fill_reg);
                    end
                    else
                    begin
                        rd_addr_next = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    result_valid_next       = 1'b1;
                    result_next.status      = arplt_pkg::STATUS_KNOWN;
                    result_next.slot_index  = arplt_pkg::SLOT_W'(cmp_idx_reg);
                    result_next.entry_total = arplt_pkg::TOTAL_W'(fill_reg);
                    state_next              = ST_IDLE;
                end
                else if (rd_en)
                begin
                    cmp_vld_next = 1'b1;
                    rd_addr_next = rd_addr_reg + CNT_W'(1);
                end
                else if (is_full)
                begin
                    result_valid_next       = 1'b1;
                    result_next.status      = arplt_pkg::STATUS_FULL;
                    result_next.slot_index  = '0;
                    result_next.entry_total = arplt_pkg::TOTAL_W'(fill_reg);
                    state_next              = ST_IDLE;
                end
                else
                begin
                    // key not present: append at the fill position
                    wr_en                   = 1'b1;
                    fill_next               = fill_reg + CNT_W'(1);
                    result_valid_next       = 1'b1;
                    result_next.status      = arplt_pkg::STATUS_ADDED;
                    result_next.slot_index  = arplt_pkg::SLOT_W'(fill_reg);
                    result_next.entry_total = arplt_pkg::TOTAL_W'(fill_next);
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign wr_addr = fill_reg[ADDR_W-1:0];
    assign wr_data = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_reg         <= '0;
            rd_addr_reg      <= '0;
            cmp_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            rd_addr_reg      <= rd_addr_next;
            cmp_vld_reg      <= cmp_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        key_reg     <= key_next;
        result_reg  <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### hdl/arp_learning_table.sv
// ----------------------------------------------------------------------------
// arp_learning_table
// Learns (source MAC, sender IP) pairs from decoded ARP frames.
// ----------------------------------------------------------------------------
// Usage:
//   Drive one decoded frame on 'frame' and raise 'start'; the item is taken
//   at the rising edge where start is high and busy is low. Busy stays high
//   while the table is scanned.
//   Exactly one result per item comes back on 'result', marked by a
//   one-cycle 'result_valid' strobe. The receiver cannot stall the block;
//   the result must be captured in that cycle.
//   Broadcast frames return status 2 in the cycle after the item, without a
//   scan. Others walk the valid entries in arrival order, one entry read
//   per cycle from the single-port-read entry store, with each compare in
//   the cycle after its read; a hit ends the scan early.
//   Busy drops so that the next item can be taken at the edge that takes
//   the result: one item per cycle for broadcasts, else one per result.
//   A new key is written into the next free slot in the same cycle the
//   result is decided; a full table answers status 3 and stays unchanged.
//   Reset clears the fill count and the control state; stored entries are
//   not cleared, since only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module arp_learning_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  arplt_pkg::arp_frame_t  frame,
    output logic                   busy,
    output logic                   result_valid,
    output arplt_pkg::arp_result_t result
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    arplt_pkg::table_entry_t wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    arplt_pkg::table_entry_t rd_data;

    // scan sequencer, fill count and result register
    arplt_scan_ctrl #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .frame        (frame),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    // MAC / IP / interface store
    arplt_table_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
